// ===== sv/ccb_pkg.sv =====
// Shared types, constants and the weight table function of the crossfade blender.
package ccb_pkg;

  // Default parameter values
  localparam int DEF_TICK_BITS    = 24;
  localparam int DEF_TABLE_BITS   = 8;
  localparam int DEF_CHANNEL_BITS = 8;

  // Register file
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int DUR_BITS      = 24;
  localparam logic [DUR_BITS-1:0] DUR_RESET = 24'd1000;
  localparam logic REG_DURATION = 1'b0;   // word index, paddr[2]

  // Q1.16 weight, 65536 is full weight
  localparam int WEIGHT_BITS = 17;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_IDX_BITS  = 2;

  // Q2.30 constants for the table build
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_TICK    = 2'd1,
    OP_PIXEL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MIX,
    ST_PUT
  } state_t;

  // Raised-cosine weight of the outgoing colour for table entry idx,
  // evaluated at elaboration: folded Taylor series of cos in Q2.30.
  function automatic logic [WEIGHT_BITS-1:0] weight_entry(input int unsigned idx,
                                                          input int unsigned tb);
    logic [63:0] full;
    logic [63:0] ii;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sum;
    logic signed [63:0] c;
    logic neg;
    full = 64'd1 << tb;
    ii   = 64'(idx) & (full - 64'd1);
    if ((ii << 1) <= full) begin
      a   = ii;
      neg = 1'b0;
    end else begin
      a   = full - ii;
      neg = 1'b1;
    end
    x  = (PI_Q30 * a + (full >> 1)) >> tb;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = ONE_Q30;
    c  = $signed(ONE_Q30);
    for (int k = 1; k <= 10; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) c = c - $signed(t);
      else              c = c + $signed(t);
    end
    if (c < 0) c = 64'sd0;
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    if (neg) c = -c;
    sum = $unsigned($signed(ONE_Q30) + c + 64'sd16384) >> 15;
    return sum[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ===== sv/ccb_if.sv =====
// Item and result channel interfaces of the crossfade blender.
interface ccb_item_if import ccb_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [CHANNEL_BITS-1:0] from_red;
  logic [CHANNEL_BITS-1:0] from_green;
  logic [CHANNEL_BITS-1:0] from_blue;
  logic [CHANNEL_BITS-1:0] to_red;
  logic [CHANNEL_BITS-1:0] to_green;
  logic [CHANNEL_BITS-1:0] to_blue;

  modport source (
    output valid, op, from_red, from_green, from_blue, to_red, to_green, to_blue,
    input  ready
  );
  modport sink (
    input  valid, op, from_red, from_green, from_blue, to_red, to_green, to_blue,
    output ready
  );
endinterface

interface ccb_result_if import ccb_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] mix_red;
  logic [CHANNEL_BITS-1:0] mix_green;
  logic [CHANNEL_BITS-1:0] mix_blue;
  logic                    fade_done;

  modport source (
    output valid, mix_red, mix_green, mix_blue, fade_done,
    input  ready
  );
  modport sink (
    input  valid, mix_red, mix_green, mix_blue, fade_done,
    output ready
  );
endinterface

// ===== sv/ccb_div.sv =====
// Restoring divider: one quotient bit per cycle of (numer << TABLE_BITS) / denom.
module ccb_div import ccb_pkg::*; #(
  parameter int TICK_BITS  = DEF_TICK_BITS,
  parameter int TABLE_BITS = DEF_TABLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TICK_BITS-1:0]  numer,   // must be below denom
  input  logic [TICK_BITS-1:0]  denom,
  output logic                  busy,
  output logic [TABLE_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(TABLE_BITS);

  logic [TICK_BITS-1:0] rem;
  logic [TICK_BITS-1:0] dvsr;
  logic [CNT_BITS-1:0]  cnt;
  logic [TICK_BITS:0]   shifted;
  logic                 qbit;
  logic [TICK_BITS-1:0] rem_next;

  // one trial subtract per cycle
  always_comb begin
    shifted = {rem, 1'b0};
    qbit    = (shifted >= {1'b0, dvsr});
    if (qbit) rem_next = TICK_BITS'(shifted - {1'b0, dvsr});
    else      rem_next = shifted[TICK_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_BITS'(1);
      if (cnt == CNT_BITS'(TABLE_BITS - 1)) busy <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      dvsr <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[TABLE_BITS-2:0], qbit};
    end
  end

endmodule

// ===== sv/ccb_mix.sv =====
// Shared blend unit: to + round((from - to) * w / 65536) for one channel.
module ccb_mix import ccb_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic [CHANNEL_BITS-1:0] from_c,
  input  logic [CHANNEL_BITS-1:0] to_c,
  input  logic [WEIGHT_BITS-1:0]  weight,
  output logic [CHANNEL_BITS-1:0] mix
);

  localparam int PW = CHANNEL_BITS + WEIGHT_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(32768);

  logic signed [CHANNEL_BITS:0] diff;
  logic signed [PW-1:0]         diff_x;
  logic signed [PW-1:0]         w_x;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         rnd;

  // to*(1-w) + from*w folded into a single signed product
  always_comb begin
    diff   = $signed({1'b0, from_c}) - $signed({1'b0, to_c});
    diff_x = PW'(diff);
    w_x    = PW'($signed({1'b0, weight}));
    prod   = diff_x * w_x;
    rnd    = (prod + HALF) >>> 16;
    mix    = to_c + rnd[CHANNEL_BITS-1:0];
  end

endmodule

// ===== sv/cosine_crossfade_blender_top.sv =====
// Top level of the raised-cosine crossfade blender: sequencer, state and register port.
//
//  channel | kind          | transaction
//  --------+---------------+----------------------------------------------
//  item    | valid/ready   | op plus from/to RGB colour
//  result  | valid/ready   | mixed RGB colour plus fade_done
//  apb     | psel/penable  | duration_ticks at byte address 0
//
//  Restart, unused op, finishing tick, pixel after the fade: idle, then put.
//  Pixel during the fade: idle, three mix steps one channel each through the multiplier, put.
//  Tick during the fade: idle, the divide state that forms TABLE_BITS quotient bits, put.
//  ready is high only while the sequencer is idle; a finished result waits
//  in the output register and holds the sequencer only if still not taken.
//  rst is synchronous and restores duration 1000 and full 'from' weight.
module cosine_crossfade_blender_top import ccb_pkg::*; #(
  parameter int TICK_BITS    = DEF_TICK_BITS,
  parameter int TABLE_BITS   = DEF_TABLE_BITS,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  ccb_item_if.sink                 item,
  ccb_result_if.source             result
);

  localparam int TABLE_SIZE = 2 ** TABLE_BITS;
  localparam int WIDE_BITS  = (TICK_BITS > DUR_BITS) ? TICK_BITS : DUR_BITS;

  state_t state;
  state_t state_next;

  logic [DUR_BITS-1:0]     duration;
  logic [TICK_BITS-1:0]    elapsed;
  logic [WEIGHT_BITS-1:0]  from_weight;
  logic                    done_flag;

  logic [CHANNEL_BITS-1:0] from_q [NUM_CHANNELS];
  logic [CHANNEL_BITS-1:0] to_q   [NUM_CHANNELS];
  logic [CHANNEL_BITS-1:0] res    [NUM_CHANNELS];
  logic [CH_IDX_BITS-1:0]  ch_idx;

  logic                    out_valid;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic                    out_done;

  logic [WIDE_BITS-1:0]    dur_wide;
  logic [WIDE_BITS-1:0]    tick_max;
  logic [TICK_BITS-1:0]    dur_eff;
  logic [TICK_BITS-1:0]    e_new;
  logic                    acc;
  logic                    out_free;
  logic                    div_start;
  logic                    div_busy;
  logic [TABLE_BITS-1:0]   quot;
  logic [CHANNEL_BITS-1:0] mix_val;
  logic [WEIGHT_BITS-1:0]  wtab [TABLE_SIZE];
  op_t                     op_in;

  // weight table, built at elaboration
  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_tab
    localparam logic [WEIGHT_BITS-1:0] ENTRY = weight_entry(gi, TABLE_BITS);
    assign wtab[gi] = ENTRY;
  end

  // register port
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_DURATION) prdata = APB_DATA_BITS'(duration);
    else                          prdata = '0;
  end

  // effective duration and the counter after a tick
  always_comb begin
    dur_wide = WIDE_BITS'(duration);
    tick_max = WIDE_BITS'({TICK_BITS{1'b1}});
    if (dur_wide > tick_max) dur_eff = TICK_BITS'(tick_max);
    else                     dur_eff = TICK_BITS'(dur_wide);
    if (elapsed < dur_eff) e_new = elapsed + TICK_BITS'(1);
    else                   e_new = dur_eff;
  end

  assign op_in    = op_t'(item.op);
  assign acc      = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  // shared units
  ccb_div #(
    .TICK_BITS  (TICK_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (e_new),
    .denom (dur_eff),
    .busy  (div_busy),
    .quot  (quot)
  );

  ccb_mix #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_mix (
    .from_c (from_q[ch_idx]),
    .to_c   (to_q[ch_idx]),
    .weight (from_weight),
    .mix    (mix_val)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (op_in == OP_TICK && e_new != dur_eff)   state_next = ST_DIV;
          else if (op_in == OP_PIXEL && !done_flag)   state_next = ST_MIX;
          else                                        state_next = ST_PUT;
        end
      end
      ST_DIV: begin
        if (!div_busy) state_next = ST_PUT;
      end
      ST_MIX: begin
        if (ch_idx == CH_IDX_BITS'(NUM_CHANNELS - 1)) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item.ready = (state == ST_IDLE);
    div_start  = (state == ST_IDLE) && item.valid && op_in == OP_TICK && e_new != dur_eff;
  end

  // control and fade state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      duration    <= DUR_RESET;
      elapsed     <= '0;
      from_weight <= WEIGHT_ONE;
      done_flag   <= 1'b0;
      out_valid   <= 1'b0;
      ch_idx      <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == REG_DURATION)
        duration <= pwdata[DUR_BITS-1:0];
      if (acc) begin
        ch_idx <= '0;
        unique case (op_in)
          OP_RESTART: begin
            elapsed     <= '0;
            from_weight <= WEIGHT_ONE;
            done_flag   <= 1'b0;
          end
          OP_TICK: begin
            elapsed <= e_new;
            if (e_new == dur_eff) done_flag <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state == ST_MIX) ch_idx <= ch_idx + CH_IDX_BITS'(1);
      if (state == ST_DIV && !div_busy) from_weight <= wtab[quot];
      if (state == ST_PUT && out_free) out_valid <= 1'b1;
      else if (result.ready)           out_valid <= 1'b0;
    end
  end

  // item capture and result assembly
  always_ff @(posedge clk) begin
    if (acc) begin
      from_q[0] <= item.from_red;
      from_q[1] <= item.from_green;
      from_q[2] <= item.from_blue;
      to_q[0]   <= item.to_red;
      to_q[1]   <= item.to_green;
      to_q[2]   <= item.to_blue;
      if (op_in == OP_PIXEL && done_flag) begin
        res[0] <= item.to_red;
        res[1] <= item.to_green;
        res[2] <= item.to_blue;
      end else begin
        res[0] <= '0;
        res[1] <= '0;
        res[2] <= '0;
      end
    end
    if (state == ST_MIX) res[ch_idx] <= mix_val;
    if (state == ST_PUT && out_free) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      out_done  <= done_flag;
    end
  end

  assign result.valid     = out_valid;
  assign result.mix_red   = out_red;
  assign result.mix_green = out_green;
  assign result.mix_blue  = out_blue;
  assign result.fade_done = out_done;

endmodule

// ===== sv/ccb_checker.sv =====
// Port-level checks of the crossfade blender, bound to the top level.
module ccb_checker import ccb_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic [CHANNEL_BITS-1:0] mix_red,
  input logic [CHANNEL_BITS-1:0] mix_green,
  input logic [CHANNEL_BITS-1:0] mix_blue,
  input logic                    fade_done
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // one item in the sequencer at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while the sequencer is busy");

  // a result is never produced in the cycle after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> !result_valid)
    else $error("result appeared without sequencer work");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(mix_red) &&
      $stable(mix_green) && $stable(mix_blue) && $stable(fade_done))
    else $error("stalled result changed");

endmodule

bind cosine_crossfade_blender_top ccb_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_ccb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .mix_red      (result.mix_red),
  .mix_green    (result.mix_green),
  .mix_blue     (result.mix_blue),
  .fade_done    (result.fade_done)
);
